[rtl/arpm_pkg.sv]
package arpm_pkg;

	// Fixed widths of the accumulator, the square root and the registers.
	localparam int SUM_W  = 48;
	localparam int ROOT_W = SUM_W / 2;
	localparam int WIN_W  = 16;
	localparam int HOLD_W = 17;
	localparam int COEF_W = 24;
	localparam int CFG_W  = 24;
	localparam int IDX_W  = 2;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_AVG_WINDOW = 2'd0;
	localparam logic [IDX_W-1:0] REG_PEAK_HOLD  = 2'd1;
	localparam logic [IDX_W-1:0] REG_PEAK_DECAY = 2'd2;

	// Register values after reset.
	localparam logic [WIN_W-1:0]  AVG_WINDOW_RST = 16'd8820;
	localparam logic [HOLD_W-1:0] PEAK_HOLD_RST  = 17'd22050;
	localparam logic [COEF_W-1:0] PEAK_DECAY_RST = 24'd16775538;

	// Command codes of an input transaction.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// Sequencer states of the top level.
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CALC = 6'b000010,
		S_LEAK = 6'b000100,
		S_ADD  = 6'b001000,
		S_MEAN = 6'b010000,
		S_ROOT = 6'b100000
	} state_t;

endpackage

[rtl/arpm_in_if.sv]
interface arpm_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          end_of_buffer;

	modport source(output valid, cmd, sample, end_of_buffer, input ready);
	modport sink(input valid, cmd, sample, end_of_buffer, output ready);
endinterface

[rtl/arpm_out_if.sv]
interface arpm_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] rms_level;
	logic [SAMPLE_BITS-1:0] peak_level;

	modport source(output valid, rms_level, peak_level, input ready);
	modport sink(input valid, rms_level, peak_level, output ready);
endinterface

[rtl/arpm_div.sv]
module arpm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [arpm_pkg::SUM_W-1:0] dividend,
	input  logic [arpm_pkg::WIN_W-1:0] divisor,
	output logic                       done,
	output logic [arpm_pkg::SUM_W-1:0] quotient,
	output logic [arpm_pkg::WIN_W-1:0] remainder
);

	localparam int CNT_W = $clog2(arpm_pkg::SUM_W);
	localparam int SW    = arpm_pkg::SUM_W;
	localparam int WW    = arpm_pkg::WIN_W;

	logic [SW-1:0]    quo_q;
	logic [WW-1:0]    rem_q;
	logic [WW-1:0]    dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WW:0]   shifted;
	logic [WW:0]   diff;
	logic          ge;

	// One restoring step: bring down the next dividend bit and try a subtract.
	assign shifted = {rem_q, quo_q[SW-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = (shifted >= {1'b0, dsr_q});

	// Control: count one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(SW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend shifts out on the left as quotient bits enter on the right.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SW-2:0], ge};
			rem_q <= ge ? diff[WW-1:0] : shifted[WW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[rtl/arpm_isqrt.sv]
module arpm_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [arpm_pkg::SUM_W-1:0]  radicand,
	output logic                        done,
	output logic [arpm_pkg::ROOT_W-1:0] root
);

	localparam int SW    = arpm_pkg::SUM_W;
	localparam int RW    = arpm_pkg::ROOT_W;
	localparam int REM_W = RW + 2;
	localparam int CNT_W = $clog2(RW);

	logic [SW-1:0]    rad_q;
	logic [REM_W-1:0] rem_q;
	logic [RW-1:0]    root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [REM_W+1:0] trial_rem;
	logic [REM_W+1:0] trial_sub;
	logic [REM_W+1:0] diff;
	logic             ge;

	// One root bit per step: append two radicand bits and test against 4*root+1.
	assign trial_rem = {rem_q, rad_q[SW-1:SW-2]};
	assign trial_sub = {2'b00, root_q, 2'b01};
	assign diff      = trial_rem - trial_sub;
	assign ge        = (trial_rem >= trial_sub);

	// Control: one step per cycle over all root bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: radicand shifts two bits left per step.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SW-3:0], 2'b00};
			rem_q  <= ge ? diff[REM_W-1:0] : trial_rem[REM_W-1:0];
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[rtl/audio_rms_peak_meter.sv]
// Level meter for signed audio samples: every sample transaction updates a leaky sum
// of squares (sum = floor(sum*(N-1)/N) + x*x, saturating at 48 bits) and a peak
// magnitude that is held for peak_hold_samples samples and then decays by the Q0.24
// peak_decay_coeff each sample. A sample marked end_of_buffer produces one output
// transaction with rms_level = floor(sqrt(floor(sum/N))), limited to full scale, and
// the current peak. A clear command zeroes all statistics. An ordinary sample is
// paced by the bit-serial 48-bit divider that retires one quotient bit per cycle;
// for an end-of-buffer sample the same divider runs a second time for the mean and
// the square root then produces one root bit per cycle. The squaring and the peak
// decay are shift-add multipliers that run alongside the first division. A finished
// result waits in the output register while the next sample is already accepted; a
// new reading that finds the previous one still waiting holds the block until it is
// taken.
module audio_rms_peak_meter #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [arpm_pkg::IDX_W-1:0]    cfg_index,
	input  logic [arpm_pkg::CFG_W-1:0]    cfg_data,
	arpm_in_if.sink                       audio,
	arpm_out_if.source                    meter
);

	localparam int SB        = SAMPLE_BITS;
	localparam int SW        = arpm_pkg::SUM_W;
	localparam int RW        = arpm_pkg::ROOT_W;
	localparam int WW        = arpm_pkg::WIN_W;
	localparam int HW        = arpm_pkg::HOLD_W;
	localparam int CW        = arpm_pkg::COEF_W;
	localparam int MUL_CNT_W = $clog2(CW + 1);
	localparam logic [SB-1:0] FULL_SCALE = {1'b1, {(SB - 1){1'b0}}};

	arpm_pkg::state_t state_q;

	// Configuration registers.
	logic [WW-1:0] win_q;
	logic [HW-1:0] hold_cfg_q;
	logic [CW-1:0] coef_q;

	// Statistics.
	logic [SW-1:0] sum_q;
	logic [SB-1:0] peak_q;
	logic [HW-1:0] hold_q;

	// Per-sample working registers.
	logic [SB-1:0]        mag_q;
	logic                 eob_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [2*SB-1:0]      sq_acc_q;
	logic [SB-1:0]        sq_mpr_q;
	logic [SB+CW-1:0]     dec_acc_q;
	logic [CW-1:0]        dec_mpr_q;

	// Output register.
	logic          out_valid_q;
	logic [SB-1:0] rms_out_q;
	logic [SB-1:0] peak_out_q;

	logic          accept;
	logic [SB-1:0] raw;
	logic [SB-1:0] mag_c;
	logic [WW-1:0] n_eff;

	logic          div_start;
	logic [SW-1:0] div_dividend;
	logic          div_done;
	logic [SW-1:0] div_quo;
	logic [WW-1:0] div_rem;

	logic          root_done;
	logic [RW-1:0] root;
	logic [SB-1:0] rms_sat;

	logic [SB:0]   sq_top;
	logic [SB:0]   dec_top;
	logic [SW:0]   sum_add;
	logic [SW-1:0] sum_sat;
	logic [SB-1:0] peak_decayed;
	logic [SB-1:0] peak_base;
	logic [HW-1:0] hold_base;
	logic          out_free;
	logic          out_set;

	assign accept      = audio.valid && audio.ready;
	assign audio.ready = (state_q == arpm_pkg::S_IDLE);

	// Sample magnitude; the most negative code maps to full scale.
	assign raw   = audio.sample;
	assign mag_c = raw[SB-1] ? (~raw + SB'(1)) : raw;

	// A window of zero acts as a window of one.
	assign n_eff = (win_q == '0) ? WW'(1) : win_q;

	// Serial multiplier steps: add the multiplicand at the top, shift right.
	assign sq_top  = {1'b0, sq_acc_q[2*SB-1:SB]} + (sq_mpr_q[0] ? {1'b0, mag_q} : '0);
	assign dec_top = {1'b0, dec_acc_q[SB+CW-1:CW]} + (dec_mpr_q[0] ? {1'b0, peak_q} : '0);

	// New sum after the leak with saturation at the accumulator width.
	assign sum_add = {1'b0, sum_q} + {1'b0, SW'(sq_acc_q)};
	assign sum_sat = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];

	// Peak either counts down its hold or decays.
	assign peak_decayed = dec_acc_q[SB+CW-1:CW];
	assign peak_base    = (hold_q != '0) ? peak_q : peak_decayed;
	assign hold_base    = (hold_q != '0) ? (hold_q - HW'(1)) : hold_q;

	// Root limited to full scale.
	assign rms_sat = (root > RW'(FULL_SCALE)) ? FULL_SCALE : root[SB-1:0];

	assign out_free = !out_valid_q || meter.ready;

	// The root is finished and the output register can take the new reading.
	assign out_set = (state_q == arpm_pkg::S_ROOT) && (cnt_q == '0) && out_free;

	// The divider runs first for the leak and again for the mean at end of buffer.
	assign div_start    = (accept && (audio.cmd == arpm_pkg::CMD_SAMPLE)) ||
	                      (state_q == arpm_pkg::S_ADD && eob_q);
	assign div_dividend = (state_q == arpm_pkg::S_ADD) ? sum_sat : sum_q;

	arpm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (n_eff),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	arpm_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == arpm_pkg::S_MEAN && div_done),
		.radicand (div_quo),
		.done     (root_done),
		.root     (root)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= arpm_pkg::AVG_WINDOW_RST;
			hold_cfg_q <= arpm_pkg::PEAK_HOLD_RST;
			coef_q     <= arpm_pkg::PEAK_DECAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				arpm_pkg::REG_AVG_WINDOW: win_q      <= cfg_data[WW-1:0];
				arpm_pkg::REG_PEAK_HOLD:  hold_cfg_q <= cfg_data[HW-1:0];
				arpm_pkg::REG_PEAK_DECAY: coef_q     <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// Output valid: set when a reading is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_set) begin
			out_valid_q <= 1'b1;
		end else if (meter.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer and statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arpm_pkg::S_IDLE;
			sum_q   <= '0;
			peak_q  <= '0;
			hold_q  <= '0;
		end else begin
			unique case (state_q)
				arpm_pkg::S_IDLE: begin
					if (accept) begin
						if (audio.cmd == arpm_pkg::CMD_CLEAR) begin
							sum_q  <= '0;
							peak_q <= '0;
							hold_q <= '0;
						end else begin
							state_q <= arpm_pkg::S_CALC;
						end
					end
				end
				arpm_pkg::S_CALC: begin
					if (div_done) begin
						state_q <= arpm_pkg::S_LEAK;
					end
				end
				arpm_pkg::S_LEAK: begin
					// sum - ceil(sum/N), as sum + ~q + (remainder is zero).
					sum_q   <= sum_q + ~div_quo + SW'(div_rem == '0);
					state_q <= arpm_pkg::S_ADD;
				end
				arpm_pkg::S_ADD: begin
					sum_q <= sum_sat;
					if (mag_q > peak_base) begin
						peak_q <= mag_q;
						hold_q <= hold_cfg_q;
					end else begin
						peak_q <= peak_base;
						hold_q <= hold_base;
					end
					state_q <= eob_q ? arpm_pkg::S_MEAN : arpm_pkg::S_IDLE;
				end
				arpm_pkg::S_MEAN: begin
					if (div_done) begin
						state_q <= arpm_pkg::S_ROOT;
					end
				end
				arpm_pkg::S_ROOT: begin
					// Wait for the root to finish and for the output register to be free.
					if (out_set) begin
						state_q <= arpm_pkg::S_IDLE;
					end
				end
				default: state_q <= arpm_pkg::S_IDLE;
			endcase
		end
	end

	// Per-sample datapath: capture, serial multipliers and the result.
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q     <= mag_c;
			eob_q     <= audio.end_of_buffer;
			cnt_q     <= '0;
			sq_acc_q  <= '0;
			sq_mpr_q  <= mag_c;
			dec_acc_q <= '0;
			dec_mpr_q <= coef_q;
		end else if (state_q == arpm_pkg::S_CALC) begin
			if (cnt_q < MUL_CNT_W'(CW)) begin
				cnt_q <= cnt_q + MUL_CNT_W'(1);
			end
			if (cnt_q < MUL_CNT_W'(SB)) begin
				sq_acc_q <= {sq_top, sq_acc_q[SB-1:1]};
				sq_mpr_q <= sq_mpr_q >> 1;
			end
			if (cnt_q < MUL_CNT_W'(CW)) begin
				dec_acc_q <= {dec_top, dec_acc_q[CW-1:1]};
				dec_mpr_q <= dec_mpr_q >> 1;
			end
		end else if (state_q == arpm_pkg::S_MEAN) begin
			// Marks that the root is not finished yet.
			cnt_q <= MUL_CNT_W'(1);
		end else if (state_q == arpm_pkg::S_ROOT) begin
			// The root stays on the unit's output once it has finished.
			if (root_done) begin
				cnt_q <= '0;
			end
			if (out_set) begin
				rms_out_q  <= rms_sat;
				peak_out_q <= peak_q;
			end
		end
	end

	assign meter.valid      = out_valid_q;
	assign meter.rms_level  = rms_out_q;
	assign meter.peak_level = peak_out_q;

	// The leak step never makes the sum larger.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == arpm_pkg::S_LEAK) |=> (sum_q <= $past(sum_q)))
		else $error("leak step increased the sum of squares");

	// Divider results arrive only while the sequencer waits for them.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == arpm_pkg::S_CALC || state_q == arpm_pkg::S_MEAN))
		else $error("divider finished outside a divide state");

	// Square root results arrive only in the root state.
	assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> (state_q == arpm_pkg::S_ROOT))
		else $error("square root finished outside the root state");

	// The held peak never exceeds full scale.
	assert property (@(posedge clk) disable iff (!arst_n)
		(peak_q <= FULL_SCALE))
		else $error("peak magnitude above full scale");

	// A result is never written while a waiting result is not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !meter.ready) |=> (out_valid_q && $stable(rms_out_q)))
		else $error("waiting result was overwritten");

endmodule

[bench/arpm_meter_checker.sv]
// Watches the configuration port and both channels, keeps its own copy of the
// meter state and compares every output transaction with the oldest predicted reading.
module arpm_meter_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [arpm_pkg::IDX_W-1:0] cfg_index,
	input  logic [arpm_pkg::CFG_W-1:0] cfg_data,
	arpm_in_if                         audio,
	arpm_out_if                        meter,
	output int                         failures,
	output int                         pending
);

	localparam int SUM_W  = arpm_pkg::SUM_W;
	localparam int WIN_W  = arpm_pkg::WIN_W;
	localparam int HOLD_W = arpm_pkg::HOLD_W;
	localparam int COEF_W = arpm_pkg::COEF_W;

	localparam logic [63:0] SUM_MAX    = (64'd1 << SUM_W) - 64'd1;
	localparam logic [63:0] FULL_SCALE = 64'd32768;

	typedef struct packed {
		logic [15:0] rms;
		logic [15:0] peak;
	} meter_reading_t;

	// Register copies.
	logic [WIN_W-1:0]  avg_win   = arpm_pkg::AVG_WINDOW_RST;
	logic [HOLD_W-1:0] hold_cfg  = arpm_pkg::PEAK_HOLD_RST;
	logic [COEF_W-1:0] decay_cfg = arpm_pkg::PEAK_DECAY_RST;

	// Meter statistics.
	logic [SUM_W-1:0]  sum_sq    = '0;
	logic [15:0]       peak_mag  = '0;
	logic [HOLD_W-1:0] hold_left = '0;

	meter_reading_t readings[$];
	int             fail_cnt = 0;

	assign failures = fail_cnt;

	// Bit-pair integer square root, rounded down.
	function automatic logic [63:0] floor_root(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] rem;
		logic [63:0] b;
		root = '0;
		rem  = v;
		b    = 64'd1 << 62;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem  = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	// Applies one input transaction to the statistics; returns 1 when it yields a reading.
	function automatic bit advance_meter(input logic clr, input logic [15:0] x,
					     input logic eob, output meter_reading_t rd);
		logic [63:0] n;
		logic [63:0] mag;
		logic [63:0] leak;
		logic [63:0] sq;
		logic [63:0] decayed;
		logic [63:0] rms;
		rd = '0;
		if (clr == arpm_pkg::CMD_CLEAR) begin
			sum_sq    = '0;
			peak_mag  = '0;
			hold_left = '0;
			return 1'b0;
		end

		// A window of zero behaves as a window of one.
		n   = (avg_win == '0) ? 64'd1 : 64'(avg_win);
		mag = x[15] ? 64'd65536 - 64'(x) : 64'(x);

		// Leaky sum of squares with saturation.
		leak = (64'(sum_sq) * (n - 64'd1)) / n;
		sq   = mag * mag;
		if (leak > SUM_MAX - sq)
			sum_sq = SUM_MAX[SUM_W-1:0];
		else
			sum_sq = SUM_W'(leak + sq);

		// Peak hold, then decay once the hold has run out.
		if (hold_left != '0) begin
			hold_left = hold_left - HOLD_W'(1);
		end else begin
			decayed  = (64'(peak_mag) * 64'(decay_cfg)) >> COEF_W;
			peak_mag = decayed[15:0];
		end
		if (mag > 64'(peak_mag)) begin
			peak_mag  = mag[15:0];
			hold_left = hold_cfg;
		end

		if (eob) begin
			rms = floor_root(64'(sum_sq) / n);
			if (rms > FULL_SCALE)
				rms = FULL_SCALE;
			rd.rms  = rms[15:0];
			rd.peak = peak_mag;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Track register writes, check readings, then predict from accepted samples.
	always @(posedge clk or negedge arst_n) begin
		meter_reading_t rd;
		meter_reading_t got;
		meter_reading_t want;
		if (!arst_n) begin
			avg_win   = arpm_pkg::AVG_WINDOW_RST;
			hold_cfg  = arpm_pkg::PEAK_HOLD_RST;
			decay_cfg = arpm_pkg::PEAK_DECAY_RST;
			sum_sq    = '0;
			peak_mag  = '0;
			hold_left = '0;
			readings.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					arpm_pkg::REG_AVG_WINDOW: avg_win   = cfg_data[WIN_W-1:0];
					arpm_pkg::REG_PEAK_HOLD:  hold_cfg  = cfg_data[HOLD_W-1:0];
					arpm_pkg::REG_PEAK_DECAY: decay_cfg = cfg_data[COEF_W-1:0];
					default: ;
				endcase
			end

			if (meter.valid && meter.ready) begin
				got.rms  = meter.rms_level;
				got.peak = meter.peak_level;
				if (readings.size() == 0) begin
					if (fail_cnt < 10)
						$display("unexpected meter reading: rms %0d peak %0d",
							 got.rms, got.peak);
					fail_cnt++;
				end else begin
					want = readings.pop_front();
					if (got.rms !== want.rms || got.peak !== want.peak) begin
						if (fail_cnt < 10)
							$display("mismatch: expected rms %0d peak %0d, got rms %0d peak %0d",
								 want.rms, want.peak, got.rms, got.peak);
						fail_cnt++;
					end
				end
			end

			if (audio.valid && audio.ready) begin
				if (advance_meter(audio.cmd, audio.sample, audio.end_of_buffer, rd))
					readings.push_back(rd);
			end

			pending <= readings.size();
		end
	end

endmodule

[bench/tb.sv]
// Drives the level meter with directed and random sample streams under several
// register settings; the checker beside the block predicts and compares the readings.
module tb;

	localparam int IDX_W  = arpm_pkg::IDX_W;
	localparam int CFG_W  = arpm_pkg::CFG_W;
	localparam int WIN_W  = arpm_pkg::WIN_W;
	localparam int HOLD_W = arpm_pkg::HOLD_W;
	localparam int COEF_W = arpm_pkg::COEF_W;

	localparam int LIMIT         = 2_000_000;
	localparam int SETTLE_CYCLES = 200;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 150;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int               failures;
	int               pending;

	int         cycles     = 0;
	int         burst_left = 0;
	bit         driving    = 1'b0;
	int         stall_left = 0;
	logic [11:0] rx_phase  = '0;

	arpm_in_if  audio_ch ();
	arpm_out_if meter_ch ();

	audio_rms_peak_meter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.audio     (audio_ch),
		.meter     (meter_ch)
	);

	arpm_meter_checker meter_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.audio     (audio_ch),
		.meter     (meter_ch),
		.failures  (failures),
		.pending   (pending)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on the total run length.
	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// Receiver: windows of steady readiness alternate with long and short stalls.
	initial begin
		meter_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rx_phase++;
			if (!arst_n) begin
				meter_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				meter_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				meter_ch.ready <= 1'b1;
				case (rx_phase[10:9])
					2'd1: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 64);
					2'd2: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 4);
					default: ;
				endcase
			end
		end
	end

	// Sends one transaction; between bursts the sender drops valid for a random gap.
	task automatic send_item(input logic c, input logic [15:0] s, input logic e);
		audio_ch.valid         <= 1'b1;
		audio_ch.cmd           <= c;
		audio_ch.sample        <= s;
		audio_ch.end_of_buffer <= e;
		driving = 1'b1;
		@(posedge clk);
		while (!audio_ch.ready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			audio_ch.valid <= 1'b0;
			driving = 1'b0;
			repeat ($urandom_range(1, 60)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
								  : $urandom_range(0, 6);
		end
	endtask

	// Stops sending and waits until every predicted reading has come back.
	task automatic settle();
		if (driving) begin
			audio_ch.valid <= 1'b0;
			driving = 1'b0;
		end
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// A sample without a reading may still be in progress.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all three registers on consecutive cycles while the block is idle.
	task automatic load_config(input logic [WIN_W-1:0] win, input logic [HOLD_W-1:0] hold,
				   input logic [COEF_W-1:0] coeff);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= arpm_pkg::REG_AVG_WINDOW;
		cfg_data  <= CFG_W'(win);
		@(posedge clk);
		cfg_index <= arpm_pkg::REG_PEAK_HOLD;
		cfg_data  <= CFG_W'(hold);
		@(posedge clk);
		cfg_index <= arpm_pkg::REG_PEAK_DECAY;
		cfg_data  <= CFG_W'(coeff);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Stimulus and verdict.
	initial begin
		int                p;
		int                i;
		logic [WIN_W-1:0]  win;
		logic [HOLD_W-1:0] hold;
		logic [COEF_W-1:0] coeff;
		logic [15:0]       s;

		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = arpm_pkg::REG_AVG_WINDOW;
		cfg_data               = '0;
		audio_ch.valid         = 1'b0;
		audio_ch.cmd           = arpm_pkg::CMD_SAMPLE;
		audio_ch.sample        = '0;
		audio_ch.end_of_buffer = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Values after reset: zero, both extremes, small values and a clear.
		send_item(arpm_pkg::CMD_SAMPLE, 16'h0000, 1'b1);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h7FFF, 1'b1);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h8000, 1'b1);
		send_item(arpm_pkg::CMD_SAMPLE, 16'hFFFF, 1'b0);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h0001, 1'b1);
		send_item(arpm_pkg::CMD_CLEAR,  16'h1234, 1'b1);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h0000, 1'b1);

		// Zero window acts as one; no hold and a zero coefficient kill the peak at once.
		load_config('0, '0, '0);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h8000, 1'b1);
		send_item(arpm_pkg::CMD_SAMPLE, 16'd100,  1'b1);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h0000, 1'b1);

		// Largest window, longest hold and a coefficient of almost one.
		load_config('1, '1, '1);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h8000, 1'b0);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h8000, 1'b0);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h8000, 1'b0);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h8000, 1'b0);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h7FFF, 1'b1);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h5555, 1'b0);
		send_item(arpm_pkg::CMD_SAMPLE, 16'hAAAA, 1'b1);

		// Shrinking the window over a large sum drives the mean past full scale;
		// the hold left from the previous setting keeps the peak at full scale throughout.
		load_config(16'd4, 17'd3, 24'h800000);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h8000, 1'b1);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h0000, 1'b1);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h0000, 1'b1);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h0000, 1'b1);
		send_item(arpm_pkg::CMD_SAMPLE, 16'h0000, 1'b1);

		// Random streams under a different register setting per phase.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 5)
				0: win = 16'd1;
				1: win = '0;
				2: win = '1;
				3: win = WIN_W'($urandom_range(2, 64));
				default: win = WIN_W'($urandom_range(1, 65535));
			endcase
			case (p % 4)
				0: hold = '0;
				1: hold = '1;
				2: hold = HOLD_W'($urandom_range(1, 20));
				default: hold = HOLD_W'($urandom_range(0, 131071));
			endcase
			case (p % 3)
				0: coeff = '1;
				1: coeff = '0;
				default: coeff = COEF_W'($urandom);
			endcase
			load_config(win, hold, coeff);

			for (i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 39) == 0) begin
					send_item(arpm_pkg::CMD_CLEAR, 16'($urandom), 1'($urandom));
				end else begin
					case ($urandom_range(0, 9))
						0: s = 16'h8000;
						1: s = 16'h7FFF;
						2: s = 16'($urandom_range(0, 31));
						3: s = 16'h0000 - 16'($urandom_range(1, 32));
						4: s = 16'($urandom_range(0, 2047)) - 16'd1024;
						default: s = 16'($urandom);
					endcase
					send_item(arpm_pkg::CMD_SAMPLE, s, $urandom_range(0, 5) == 0);
				end
			end
		end

		settle();
		if (failures == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[audio_rms_peak_meter.f]
rtl/arpm_pkg.sv
rtl/arpm_in_if.sv
rtl/arpm_out_if.sv
rtl/arpm_div.sv
rtl/arpm_isqrt.sv
rtl/audio_rms_peak_meter.sv
bench/arpm_meter_checker.sv
bench/tb.sv
